>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks on clk, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

>>> rtl/mcs_pkg.sv
// ----------------------------------------------------------------------------
// mcs_pkg
// Types, codes and constants shared by the motion command segmenter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcs_pkg;

  localparam int MAX_SEGMENTS = 62;
  localparam int SEC_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int CFG_W        = 48;
  localparam int DIV_W        = 48;
  localparam int DIV_CNT_W    = $clog2(DIV_W + 1);
  localparam int ROOT_STEPS   = 32;
  localparam int CNT_W        = $clog2(ROOT_STEPS);

  localparam logic [15:0] DEFAULT_FEED = 16'd3000;
  localparam logic [31:0] PAUSE_HEIGHT = 32'd1638400;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAX_R2 = 2'd0;
  localparam logic [1:0] CFG_MAX_H  = 2'd1;
  localparam logic [1:0] CFG_MIN_H  = 2'd2;
  localparam logic [1:0] CFG_SEG_T  = 2'd3;

  // Result kinds.
  localparam logic [3:0] KIND_MOVE   = 4'd0;
  localparam logic [3:0] KIND_TOOL   = 4'd1;
  localparam logic [3:0] KIND_SETE   = 4'd2;
  localparam logic [3:0] KIND_FAN    = 4'd3;
  localparam logic [3:0] KIND_LASER  = 4'd4;
  localparam logic [3:0] KIND_HEATER = 4'd5;
  localparam logic [3:0] KIND_PAUSE  = 4'd6;
  localparam logic [3:0] KIND_DWELL  = 4'd7;
  localparam logic [3:0] KIND_HOME   = 4'd8;
  localparam logic [3:0] KIND_RANGE  = 4'd9;
  localparam logic [3:0] KIND_MULTI  = 4'd10;

  // Channels.
  localparam logic [1:0] CH_MAIN  = 2'd0;
  localparam logic [1:0] CH_HEAD  = 2'd1;
  localparam logic [1:0] CH_BLOCK = 2'd2;
  localparam logic [1:0] CH_PAUSE = 2'd3;

  // Control codes without the move bit.
  localparam logic [7:0] CODE_HOME     = 8'd1;
  localparam logic [7:0] CODE_ABSOLUTE = 8'd2;
  localparam logic [7:0] CODE_RELATIVE = 8'd3;
  localparam logic [7:0] CODE_PAUSE_H  = 8'd5;
  localparam logic [7:0] CODE_PAUSE_0  = 8'd6;
  localparam logic [7:0] CODE_PAUSE_A  = 8'd7;

  typedef struct packed {
    logic [7:0]         mode;
    logic [15:0]        feed_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] extruder_value;
    logic signed [31:0] aux_value;
  } in_word_t;

  typedef struct packed {
    logic [3:0]         kind;
    logic [1:0]         channel;
    logic [15:0]        feed_out;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_e;
    logic [4:0]         field_mask;
    logic [2:0]         index;
    logic signed [31:0] value;
    logic               last;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_RAD2, ST_CHECK, ST_TOOL, ST_SETE, ST_PLAN, ST_SQ,
    ST_ROOT, ST_SCALE, ST_SEG_GO, ST_SEG_WAIT, ST_AX_GO, ST_AX_WAIT, ST_POINT,
    ST_FINAL
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_ACCEPT, OP_PREP, OP_RAD2, OP_MODE, OP_TOOL, OP_DELTA, OP_SQ,
    OP_ROOT, OP_SCALE, OP_SEG_GO, OP_SEG_LATCH, OP_AX_GO, OP_AX_LATCH,
    OP_POINT, OP_FINAL
  } dp_op_t;

  typedef enum logic [2:0] {
    REC_SINGLE, REC_ERR_RANGE, REC_ERR_MULTI, REC_TOOL, REC_SETE, REC_POINT,
    REC_FINAL
  } rec_sel_t;

  typedef struct packed {
    dp_op_t     op;
    rec_sel_t   rec;
    logic       emit;
    logic [1:0] sel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_move;
    logic has_single;
    logic illegal;
    logic multi;
    logic tool_chg;
    logic any_known;
    logic div_done;
    logic sec_gt1;
    logic pts_done;
    logic out_free;
  } dp_sts_t;

endpackage

>>> rtl/mcs_div.sv
// ----------------------------------------------------------------------------
// mcs_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcs_div import mcs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quot,
  output logic [DIV_W-1:0] rem
);

  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [DIV_W-1:0]     quot_r, rem_r, dsr_r;
  logic [DIV_W:0]       trial, diff;
  logic                 ge;

  assign trial = {rem_r, quot_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= DIV_CNT_W'(DIV_W);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == DIV_CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      dsr_r  <= divisor;
    end else if (cnt_r != '0) begin
      quot_r <= {quot_r[DIV_W-2:0], ge};
      rem_r  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

>>> rtl/mcs_dp.sv
// ----------------------------------------------------------------------------
// mcs_dp
// Datapath: machine state, limit checks, length root, segment division,
// incremental interpolation and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcs_dp import mcs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  in_word_t         in_data,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             out_stall,
  output logic             out_valid,
  output out_word_t        out_data,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts
);

  // Configuration.
  logic [47:0]        max_r2_r;
  logic signed [31:0] max_h_r, min_h_r;
  logic [30:0]        seg_t_r;

  // Machine state.
  logic signed [31:0] cur_x_r, cur_y_r, cur_z_r;
  logic [2:0]         known_r;
  logic signed [31:0] ext_r [3];
  logic [15:0]        cur_feed_r;
  logic [1:0]         tool_r;
  logic               abs_r;

  // Per-command working registers.
  in_word_t           in_r;
  logic [1:0]         t_r;
  logic signed [31:0] zadj_r, ev_r;
  logic               zp_r, ep_r, multi_r, rad_en_r, hfail_r, feed_pend_r, halve_r;
  logic [15:0]        feed_r;
  logic [63:0]        p0_r, p1_r, acc_r, rt_r, b_r;
  logic [32:0]        dm_r [4];
  logic [3:0]         neg_r;
  logic [31:0]        a_r [3];
  logic [39:0]        len100_r;
  logic [46:0]        den_r;
  logic [SEC_W-1:0]   sec_r, pt_r;
  logic [32:0]        qd_r [4];
  logic [32:0]        qa_r [4];
  logic [SEC_W-1:0]   rd_r [4];
  logic [SEC_W-1:0]   ra_r [4];

  logic      out_valid_r;
  out_word_t out_r;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    return v[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Decode of the latched command byte.
  logic [7:0] m;
  logic       xp, yp;
  assign m  = in_r.mode;
  assign xp = m[5];
  assign yp = m[4];

  logic signed [31:0] ext_t;
  always_comb begin
    unique case (t_r)
      2'd1:    ext_t = ext_r[1];
      2'd2:    ext_t = ext_r[2];
      default: ext_t = ext_r[0];
    endcase
  end

  // Preparation values.
  logic [15:0]        fv, f1, f_eff;
  logic signed [31:0] zsat, evsat, rx, ry;
  logic [31:0]        mrx, mry;
  logic [1:0]         ecount;
  assign fv     = m[6] ? in_r.feed_value : 16'd0;
  assign f1     = (fv != 16'd0) ? fv : cur_feed_r;
  assign f_eff  = (f1 != 16'd0) ? f1 : DEFAULT_FEED;
  assign zsat   = sat33(33'(in_r.pos_z) + 33'(cur_z_r));
  assign evsat  = sat33(33'(in_r.extruder_value) + 33'(ext_t));
  assign rx     = xp ? in_r.pos_x : cur_x_r;
  assign ry     = yp ? in_r.pos_y : cur_y_r;
  assign mrx    = mag32(rx);
  assign mry    = mag32(ry);
  assign ecount = 2'(m[2]) + 2'(m[1]) + 2'(m[0]);

  // Deltas.
  logic signed [32:0] d_c [4];
  logic [32:0]        dm_c [4];
  logic               halve_c;
  always_comb begin
    d_c[0] = (xp && known_r[0]) ? 33'(in_r.pos_x) - 33'(cur_x_r) : 33'sd0;
    d_c[1] = (yp && known_r[1]) ? 33'(in_r.pos_y) - 33'(cur_y_r) : 33'sd0;
    d_c[2] = (zp_r && known_r[2]) ? 33'(zadj_r) - 33'(cur_z_r) : 33'sd0;
    d_c[3] = ep_r ? 33'(ev_r) - 33'(ext_t) : 33'sd0;
    for (int k = 0; k < 4; k++) begin
      dm_c[k] = d_c[k][32] ? 33'(-d_c[k]) : 33'(d_c[k]);
    end
    halve_c = |{dm_c[0][32:31], dm_c[1][32:31], dm_c[2][32:31]};
  end

  // Sum of squares, one axis a cycle.
  logic [31:0] sq_op;
  logic [63:0] sq_p;
  always_comb begin
    case (cmd.sel)
      2'd0:    sq_op = a_r[0];
      2'd1:    sq_op = a_r[1];
      default: sq_op = a_r[2];
    endcase
  end
  assign sq_p = 64'(sq_op) * 64'(sq_op);

  // Root step.
  logic [63:0] rb;
  assign rb = rt_r + b_r;

  // Scaling.
  logic [32:0] len33;
  logic [30:0] st;
  assign len33 = halve_r ? {rt_r[31:0], 1'b0} : {1'b0, rt_r[31:0]};
  assign st    = (seg_t_r != 31'd0) ? seg_t_r : 31'd1;

  // Shared divider.
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_a, div_b, div_q, div_rem;
  assign div_start = (cmd.op == OP_SEG_GO) || (cmd.op == OP_AX_GO);
  assign div_a     = (cmd.op == OP_SEG_GO) ? DIV_W'(len100_r) : DIV_W'(dm_r[cmd.sel]);
  assign div_b     = (cmd.op == OP_SEG_GO) ? DIV_W'(den_r) : DIV_W'(sec_r);

  mcs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  // Interpolated coordinates and next accumulator values.
  logic [SEC_W:0]     rs [4];
  logic [32:0]        qs [4];
  logic signed [31:0] base [4];
  logic signed [31:0] pt_c [4];
  always_comb begin
    base[0] = cur_x_r;
    base[1] = cur_y_r;
    base[2] = cur_z_r;
    base[3] = ext_t;
    for (int k = 0; k < 4; k++) begin
      rs[k]   = {1'b0, ra_r[k]} + {1'b0, rd_r[k]};
      qs[k]   = neg_r[k] ? 33'(-qa_r[k]) : qa_r[k];
      pt_c[k] = base[k] + $signed(qs[k][31:0]);
    end
  end

  // Single-record commands.
  logic               sgl_ok;
  logic [3:0]         sgl_kind;
  logic [1:0]         sgl_ch;
  logic [2:0]         sgl_idx;
  logic signed [31:0] sgl_val;
  logic signed [39:0] laser_p, laser_b;
  logic signed [32:0] dwell_b;
  assign laser_p = 40'(in_r.aux_value) * 40'sd255;
  assign laser_b = laser_p + (laser_p[39] ? 40'sd65535 : 40'sd0);
  assign dwell_b = 33'(in_r.aux_value) + (in_r.aux_value[31] ? 33'sd65535 : 33'sd0);

  always_comb begin
    sgl_ok   = 1'b1;
    sgl_kind = KIND_HOME;
    sgl_ch   = CH_MAIN;
    sgl_idx  = 3'd0;
    sgl_val  = '0;
    if (m[6]) begin
      sgl_ok = 1'b0;
    end else if (m[5] && m[4]) begin
      sgl_kind = KIND_FAN;
      sgl_ch   = CH_HEAD;
      sgl_val  = in_r.aux_value;
    end else if (m[5]) begin
      sgl_kind = KIND_LASER;
      sgl_val  = 32'(laser_b >>> 16);
    end else if (m[4]) begin
      sgl_kind = KIND_HEATER;
      sgl_ch   = m[3] ? CH_BLOCK : CH_HEAD;
      sgl_idx  = m[2:0];
      sgl_val  = in_r.aux_value;
    end else if (m == CODE_PAUSE_A) begin
      sgl_kind = KIND_PAUSE;
      sgl_ch   = CH_PAUSE;
      sgl_val  = in_r.aux_value;
    end else if (m == CODE_PAUSE_0) begin
      sgl_kind = KIND_PAUSE;
      sgl_ch   = CH_PAUSE;
    end else if (m == CODE_PAUSE_H) begin
      sgl_kind = KIND_PAUSE;
      sgl_ch   = CH_PAUSE;
      sgl_val  = PAUSE_HEIGHT;
    end else if (m[2]) begin
      sgl_kind = KIND_DWELL;
      sgl_val  = 32'(dwell_b >>> 16);
    end else if (m != CODE_HOME) begin
      sgl_ok = 1'b0;
    end
  end

  // Result builder.
  out_word_t rec;
  always_comb begin
    rec = '0;
    unique case (cmd.rec)
      REC_SINGLE: begin
        rec.kind    = sgl_kind;
        rec.channel = sgl_ch;
        rec.index   = sgl_idx;
        rec.value   = sgl_val;
        rec.last    = 1'b1;
      end
      REC_ERR_RANGE: begin
        rec.kind = KIND_RANGE;
        rec.last = 1'b1;
      end
      REC_ERR_MULTI: begin
        rec.kind = KIND_MULTI;
        rec.last = 1'b1;
      end
      REC_TOOL: begin
        rec.kind  = KIND_TOOL;
        rec.index = 3'(t_r);
      end
      REC_SETE: begin
        rec.kind  = KIND_SETE;
        rec.value = ext_t;
      end
      REC_POINT: begin
        rec.kind = KIND_MOVE;
        if (feed_pend_r) begin
          rec.field_mask[4] = 1'b1;
          rec.feed_out      = feed_r;
        end
        if (dm_r[0] != '0) begin
          rec.field_mask[3] = 1'b1;
          rec.out_x         = pt_c[0];
        end
        if (dm_r[1] != '0) begin
          rec.field_mask[2] = 1'b1;
          rec.out_y         = pt_c[1];
        end
        if (dm_r[2] != '0) begin
          rec.field_mask[1] = 1'b1;
          rec.out_z         = pt_c[2];
        end
        if (dm_r[3] != '0) begin
          rec.field_mask[0] = 1'b1;
          rec.out_e         = pt_c[3];
        end
      end
      REC_FINAL: begin
        rec.kind = KIND_MOVE;
        rec.last = 1'b1;
        if (feed_pend_r) begin
          rec.field_mask[4] = 1'b1;
          rec.feed_out      = feed_r;
        end
        if (xp) begin
          rec.field_mask[3] = 1'b1;
          rec.out_x         = in_r.pos_x;
        end
        if (yp) begin
          rec.field_mask[2] = 1'b1;
          rec.out_y         = in_r.pos_y;
        end
        if (zp_r) begin
          rec.field_mask[1] = 1'b1;
          rec.out_z         = zadj_r;
        end
        if (ep_r) begin
          rec.field_mask[0] = 1'b1;
          rec.out_e         = ev_r;
        end
      end
      default: rec = '0;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r2_r <= '1;
      max_h_r  <= 32'sh7fff_ffff;
      min_h_r  <= 32'sh8000_0000;
      seg_t_r  <= 31'd65536;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MAX_R2: max_r2_r <= cfg_wdata[47:0];
        CFG_MAX_H:  max_h_r  <= $signed(cfg_wdata[31:0]);
        CFG_MIN_H:  min_h_r  <= $signed(cfg_wdata[31:0]);
        CFG_SEG_T:  seg_t_r  <= cfg_wdata[30:0];
        default:    seg_t_r  <= seg_t_r;
      endcase
    end
  end

  // Machine state, committed only by tool changes, mode codes, interpolated points and final points.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      cur_z_r     <= '0;
      known_r     <= '0;
      ext_r[0]    <= '0;
      ext_r[1]    <= '0;
      ext_r[2]    <= '0;
      cur_feed_r  <= DEFAULT_FEED;
      tool_r      <= '0;
      abs_r       <= 1'b1;
      feed_pend_r <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_MODE: begin
          if (m == CODE_RELATIVE) abs_r <= 1'b0;
          else if (m == CODE_ABSOLUTE) abs_r <= 1'b1;
        end
        OP_PREP:  feed_pend_r <= (f_eff != cur_feed_r);
        OP_TOOL:  tool_r <= t_r;
        OP_POINT: begin
          feed_pend_r <= 1'b0;
          cur_feed_r  <= feed_r;
        end
        OP_FINAL: begin
          feed_pend_r <= 1'b0;
          cur_feed_r  <= feed_r;
          if (xp) begin
            cur_x_r    <= in_r.pos_x;
            known_r[0] <= 1'b1;
          end
          if (yp) begin
            cur_y_r    <= in_r.pos_y;
            known_r[1] <= 1'b1;
          end
          if (zp_r) begin
            cur_z_r    <= zadj_r;
            known_r[2] <= 1'b1;
          end
          if (ep_r) begin
            unique case (t_r)
              2'd1:    ext_r[1] <= ev_r;
              2'd2:    ext_r[2] <= ev_r;
              default: ext_r[0] <= ev_r;
            endcase
          end
        end
        default: feed_pend_r <= feed_pend_r;
      endcase
    end
  end

  // Working registers, no reset needed.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT: begin
        in_r <= in_data;
        t_r  <= in_data.mode[0] ? 2'd2 : (in_data.mode[1] ? 2'd1 : 2'd0);
      end
      OP_PREP: begin
        zadj_r   <= abs_r ? in_r.pos_z : zsat;
        zp_r     <= m[3] && (abs_r || known_r[2]);
        ev_r     <= abs_r ? in_r.extruder_value : evsat;
        ep_r     <= (ecount == 2'd1);
        multi_r  <= (ecount > 2'd1);
        rad_en_r <= (xp || known_r[0]) && (yp || known_r[1]);
        feed_r   <= f_eff;
        p0_r     <= 64'(mrx) * 64'(mrx);
      end
      OP_RAD2: begin
        p1_r    <= 64'(mry) * 64'(mry);
        hfail_r <= zp_r && ((zadj_r > max_h_r) || (zadj_r < min_h_r));
      end
      OP_DELTA: begin
        for (int k = 0; k < 4; k++) begin
          dm_r[k]  <= dm_c[k];
          neg_r[k] <= d_c[k][32];
        end
        for (int k = 0; k < 3; k++) begin
          a_r[k] <= halve_c ? dm_c[k][32:1] : dm_c[k][31:0];
        end
        halve_r <= halve_c;
        acc_r   <= '0;
        rt_r    <= '0;
        b_r     <= 64'h4000_0000_0000_0000;
      end
      OP_SQ: acc_r <= acc_r + sq_p;
      OP_ROOT: begin
        if (acc_r >= rb) begin
          acc_r <= acc_r - rb;
          rt_r  <= (rt_r >> 1) + b_r;
        end else begin
          rt_r <= rt_r >> 1;
        end
        b_r <= b_r >> 2;
      end
      OP_SCALE: begin
        len100_r <= 40'(len33) * 40'd100;
        den_r    <= 47'(feed_r) * 47'(st);
      end
      OP_SEG_LATCH: begin
        sec_r <= (div_q > DIV_W'(MAX_SEGMENTS)) ? SEC_W'(MAX_SEGMENTS) : div_q[SEC_W-1:0];
        pt_r  <= SEC_W'(1);
      end
      OP_AX_LATCH: begin
        qd_r[cmd.sel] <= div_q[32:0];
        qa_r[cmd.sel] <= div_q[32:0];
        rd_r[cmd.sel] <= div_rem[SEC_W-1:0];
        ra_r[cmd.sel] <= div_rem[SEC_W-1:0];
      end
      OP_POINT: begin
        pt_r <= pt_r + 1'b1;
        for (int k = 0; k < 4; k++) begin
          if (rs[k] >= {1'b0, sec_r}) begin
            ra_r[k] <= SEC_W'(rs[k] - {1'b0, sec_r});
            qa_r[k] <= qa_r[k] + qd_r[k] + 33'd1;
          end else begin
            ra_r[k] <= rs[k][SEC_W-1:0];
            qa_r[k] <= qa_r[k] + qd_r[k];
          end
        end
      end
      default: hfail_r <= hfail_r;
    endcase
  end

  // Result register: a new word loads while the old one is being taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_r <= rec;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sts.is_move    = m[7];
    sts.has_single = sgl_ok;
    sts.illegal    = hfail_r || (rad_en_r && ((p0_r + p1_r) > {max_r2_r, 16'h0000}));
    sts.multi      = multi_r;
    sts.tool_chg   = ep_r && (tool_r != t_r);
    sts.any_known  = |known_r;
    sts.div_done   = div_done;
    sts.sec_gt1    = sec_r > SEC_W'(1);
    sts.pts_done   = pt_r >= sec_r;
    sts.out_free   = !out_valid_r || !out_stall;
  end

endmodule

>>> rtl/mcs_ctrl.sv
// ----------------------------------------------------------------------------
// mcs_ctrl
// Sequencer: steps one command through checks, length, division and points.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcs_ctrl import mcs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.op    = OP_NONE;
    cmd.rec   = REC_SINGLE;
    cmd.emit  = 1'b0;
    cmd.sel   = cnt_r[1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_ACCEPT;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.is_move) begin
          cmd.op    = OP_PREP;
          state_nxt = ST_RAD2;
        end else if (!sts.has_single) begin
          cmd.op    = OP_MODE;
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_RAD2: begin
        cmd.op    = OP_RAD2;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.illegal || sts.multi) begin
          cmd.rec = sts.illegal ? REC_ERR_RANGE : REC_ERR_MULTI;
          if (sts.out_free) begin
            cmd.emit  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = sts.tool_chg ? ST_TOOL : ST_PLAN;
        end
      end
      ST_TOOL: begin
        cmd.rec = REC_TOOL;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_SETE;
        end
      end
      ST_SETE: begin
        cmd.rec = REC_SETE;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.op    = OP_TOOL;
          state_nxt = ST_PLAN;
        end
      end
      ST_PLAN: begin
        cmd.op    = OP_DELTA;
        cnt_nxt   = '0;
        state_nxt = sts.any_known ? ST_SQ : ST_FINAL;
      end
      ST_SQ: begin
        cmd.op = OP_SQ;
        if (cnt_r == CNT_W'(2)) begin
          cnt_nxt   = '0;
          state_nxt = ST_ROOT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ROOT: begin
        cmd.op  = OP_ROOT;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_STEPS - 1)) state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.op    = OP_SCALE;
        state_nxt = ST_SEG_GO;
      end
      ST_SEG_GO: begin
        cmd.op    = OP_SEG_GO;
        state_nxt = ST_SEG_WAIT;
      end
      ST_SEG_WAIT: begin
        if (sts.div_done) begin
          cmd.op    = OP_SEG_LATCH;
          cnt_nxt   = '0;
          state_nxt = ST_AX_GO;
        end
      end
      ST_AX_GO: begin
        if (!sts.sec_gt1) begin
          state_nxt = ST_FINAL;
        end else begin
          cmd.op    = OP_AX_GO;
          state_nxt = ST_AX_WAIT;
        end
      end
      ST_AX_WAIT: begin
        if (sts.div_done) begin
          cmd.op  = OP_AX_LATCH;
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = (cnt_r == CNT_W'(3)) ? ST_POINT : ST_AX_GO;
        end
      end
      ST_POINT: begin
        cmd.rec = REC_POINT;
        if (sts.pts_done) begin
          state_nxt = ST_FINAL;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.op   = OP_POINT;
        end
      end
      ST_FINAL: begin
        cmd.rec = REC_FINAL;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.op    = OP_FINAL;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

>>> rtl/motion_command_segmenter.sv
// ----------------------------------------------------------------------------
// motion_command_segmenter: one command word in, its result words out.
// Control codes are decoded and answered directly. Moves pass through the
// 48-step divider (used up to five times) and the 32-step length root; one
// command is in work at a time.
// Synchronous active-low reset restores the default limits, feed and modes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module motion_command_segmenter import mcs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mcs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Only one command is in work, so an accepted word closes the input side.
  `ASSERT_PROP(a_one_cmd, (in_valid && !in_stall) |=> in_stall, "second word accepted")
  // A word is only loaded when the result register can take it.
  `ASSERT_NEVER(a_no_overwrite, cmd.emit && !sts.out_free, "result word overwritten")
  // The final word of a command and the return to idle go together.
  `ASSERT_PROP(a_last_idle, cmd.emit |=> (out_valid && (out_data.last != in_stall)),
               "last flag out of step with idle")

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Motion command segmenter testbench
// Streams directed and random command words through the segmenter under
// random idling and stall on both sides. An in-bench model predicts every
// result word, which the monitor compares field by field. Limit registers
// are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import mcs_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_word_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_word_t        out_data;
  logic             cfg_wr_en = 1'b0;
  logic [1:0]       cfg_index = CFG_MAX_R2;
  logic [CFG_W-1:0] cfg_wdata = '0;

  motion_command_segmenter i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model of the block: limits and machine state.
  logic [47:0]        lim_r2;
  logic signed [31:0] lim_hi, lim_lo;
  logic [30:0]        seg_time;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic [2:0]         known;
  logic signed [31:0] ext_pos [3];
  logic [15:0]        feed_cur;
  logic [1:0]         tool;
  bit                 abs_mode;

  in_word_t  pend_q [$];
  out_word_t want_q [$];
  int        n_err = 0;
  int        cyc = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic bit [63:0] root64(bit [63:0] n);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit [63:0] mag64(longint v);
    return v < 0 ? -v : v;
  endfunction

  task automatic push_one(logic [3:0] k, logic [1:0] ch, logic [2:0] ix, longint v);
    out_word_t r;
    r = '0;
    r.kind = k;
    r.channel = ch;
    r.index = ix;
    r.value = v[31:0];
    r.last = 1'b1;
    want_q.push_back(r);
  endtask

  task automatic predict_move(in_word_t w);
    logic [7:0] m;
    logic [15:0] f;
    bit xp, yp, zp, ep, bad;
    longint x, y, z, ev, rx, ry, dx, dy, dz, de, sec;
    bit [63:0] s, ax, ay, az, len, st;
    bit halve;
    int ecount, t;
    out_word_t r;
    m = w.mode;
    f = m[6] ? w.feed_value : 16'd0;
    xp = m[5]; yp = m[4]; zp = m[3];
    x = w.pos_x; y = w.pos_y; z = w.pos_z; ev = w.extruder_value;
    bad = 0; ep = 0; ecount = 0; t = 0;
    dx = 0; dy = 0; dz = 0; de = 0; sec = 0;
    if ((xp || known[0]) && (yp || known[1])) begin
      rx = xp ? x : longint'(pos_x);
      ry = yp ? y : longint'(pos_y);
      s = mag64(rx) * mag64(rx) + mag64(ry) * mag64(ry);
      if ((s >> 16) > lim_r2 || ((s >> 16) == lim_r2 && s[15:0] != 0)) bad = 1;
    end
    if (zp) begin
      if (!abs_mode) begin
        if (known[2]) z = sat32(z + pos_z);
        else zp = 0;
      end
      if (zp && (z > lim_hi || z < lim_lo)) bad = 1;
    end
    for (int i = 0; i < 3; i++)
      if (m[2-i]) begin
        ecount++;
        t = i;
      end
    if (bad) begin
      push_one(KIND_RANGE, CH_MAIN, 0, 0);
      return;
    end
    if (ecount > 1) begin
      push_one(KIND_MULTI, CH_MAIN, 0, 0);
      return;
    end
    if (ecount == 1) begin
      ep = 1;
      if (!abs_mode) ev = sat32(ev + ext_pos[t]);
      if (tool != t) begin
        tool = 2'(t);
        r = '0;
        r.kind = KIND_TOOL;
        r.index = 3'(t);
        want_q.push_back(r);
        r = '0;
        r.kind = KIND_SETE;
        r.value = ext_pos[t];
        want_q.push_back(r);
      end
    end
    if (f == 0) f = feed_cur;
    if (f == 0) f = DEFAULT_FEED;
    if (known != 0) begin
      if (xp && known[0]) dx = x - pos_x;
      if (yp && known[1]) dy = y - pos_y;
      if (zp && known[2]) dz = z - pos_z;
      if (ep) de = ev - ext_pos[tool];
      ax = mag64(dx); ay = mag64(dy); az = mag64(dz);
      halve = (ax | ay | az) >= 64'h8000_0000;
      if (halve) begin
        ax >>= 1; ay >>= 1; az >>= 1;
      end
      len = root64(ax * ax + ay * ay + az * az);
      if (halve) len <<= 1;
      st = (seg_time != 0) ? seg_time : 1;
      len = (len * 100) / (64'(f) * st);
      sec = (len > MAX_SEGMENTS) ? MAX_SEGMENTS : longint'(len);
      for (longint i = 1; i < sec; i++) begin
        r = '0;
        if (f != feed_cur) begin
          r.field_mask[4] = 1; r.feed_out = f; feed_cur = f;
        end
        if (dx != 0) begin
          r.field_mask[3] = 1; r.out_x = 32'(pos_x + dx * i / sec);
        end
        if (dy != 0) begin
          r.field_mask[2] = 1; r.out_y = 32'(pos_y + dy * i / sec);
        end
        if (dz != 0) begin
          r.field_mask[1] = 1; r.out_z = 32'(pos_z + dz * i / sec);
        end
        if (de != 0) begin
          r.field_mask[0] = 1; r.out_e = 32'(ext_pos[tool] + de * i / sec);
        end
        want_q.push_back(r);
      end
    end
    r = '0;
    if (f != feed_cur) begin
      r.field_mask[4] = 1; r.feed_out = f; feed_cur = f;
    end
    if (xp) begin
      r.field_mask[3] = 1; r.out_x = 32'(x); pos_x = 32'(x); known[0] = 1;
    end
    if (yp) begin
      r.field_mask[2] = 1; r.out_y = 32'(y); pos_y = 32'(y); known[1] = 1;
    end
    if (zp) begin
      r.field_mask[1] = 1; r.out_z = 32'(z); pos_z = 32'(z); known[2] = 1;
    end
    if (ep) begin
      r.field_mask[0] = 1; r.out_e = 32'(ev); ext_pos[tool] = 32'(ev);
    end
    r.last = 1;
    want_q.push_back(r);
  endtask

  task automatic predict_command(in_word_t w);
    logic [7:0] m;
    longint aux;
    m = w.mode;
    aux = w.aux_value;
    if (m[7]) predict_move(w);
    else if (m[6]) ;
    else if (m[5:4] == 2'b11) push_one(KIND_FAN, CH_HEAD, 0, aux);
    else if (m[5]) push_one(KIND_LASER, CH_MAIN, 0, aux * 255 / 65536);
    else if (m[4]) push_one(KIND_HEATER, m[3] ? CH_BLOCK : CH_HEAD, m[2:0], aux);
    else if (m == CODE_PAUSE_A) push_one(KIND_PAUSE, CH_PAUSE, 0, aux);
    else if (m == CODE_PAUSE_0) push_one(KIND_PAUSE, CH_PAUSE, 0, 0);
    else if (m == CODE_PAUSE_H) push_one(KIND_PAUSE, CH_PAUSE, 0, PAUSE_HEIGHT);
    else if (m[2]) push_one(KIND_DWELL, CH_MAIN, 0, aux / 65536);
    else if (m == CODE_RELATIVE) abs_mode = 0;
    else if (m == CODE_ABSOLUTE) abs_mode = 1;
    else if (m == CODE_HOME) push_one(KIND_HOME, CH_MAIN, 0, 0);
  endtask

  // Idle with a chance of 37 in a hundred, except for a quiet stretch.
  function automatic bit idle_roll();
    if (cyc % 40000 >= 28000) return 0;
    return $urandom_range(0, 99) < 37;
  endfunction

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // Word driver.
  always @(posedge clk) begin
    bit nv;
    in_word_t nd;
    nv = in_valid;
    nd = in_data;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_command(in_data);
        nv = 0;
      end
      if (!nv && pend_q.size() > 0 && !idle_roll()) begin
        nd = pend_q.pop_front();
        nv = 1;
      end
    end
    in_valid <= nv;
    in_data <= nd;
  end

  // Result monitor.
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (want_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result word %p", out_data);
      end else begin
        e = want_q.pop_front();
        if (out_data.kind !== e.kind || out_data.channel !== e.channel ||
            out_data.feed_out !== e.feed_out || out_data.out_x !== e.out_x ||
            out_data.out_y !== e.out_y || out_data.out_z !== e.out_z ||
            out_data.out_e !== e.out_e || out_data.field_mask !== e.field_mask ||
            out_data.index !== e.index || out_data.value !== e.value ||
            out_data.last !== e.last) begin
          n_err++;
          if (n_err <= 10) $display("mismatch: expected %p, got %p", e, out_data);
        end
      end
    end
    out_stall <= rst_n ? idle_roll() : 1'b0;
  end

  function automatic in_word_t cmd(logic [7:0] m, logic [15:0] f, logic [31:0] x,
                                   logic [31:0] y, logic [31:0] z, logic [31:0] e,
                                   logic [31:0] a);
    in_word_t w;
    w.mode = m; w.feed_value = f; w.pos_x = x; w.pos_y = y; w.pos_z = z;
    w.extruder_value = e; w.aux_value = a;
    return w;
  endfunction

  function automatic logic [31:0] coord();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, 160 << 16) - (80 << 16);
    return $urandom;
  endfunction

  function automatic in_word_t rand_move();
    logic [7:0] m;
    logic [15:0] f;
    int r;
    m = 8'h80 | 8'($urandom & 8'h78);
    r = $urandom_range(0, 9);
    if (r < 8) m[$urandom_range(0, 2)] = 1;
    else if (r == 9) m[2:0] = 3'b011 | 3'($urandom & 3'b100);
    case ($urandom_range(0, 9))
      0: f = 16'hFFFF;
      1: f = 16'($urandom);
      default: f = 16'($urandom_range(40, 6000));
    endcase
    return cmd(m, f, coord(), coord(), coord(), coord(), $urandom);
  endfunction

  function automatic in_word_t rand_control();
    logic [7:0] m;
    m = 8'($urandom_range(0, 127));
    if ($urandom_range(0, 3) == 0) m = 8'($urandom_range(CODE_HOME, CODE_PAUSE_A));
    return cmd(m, 16'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [47:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_MAX_R2: lim_r2 = v;
      CFG_MAX_H:  lim_hi = v[31:0];
      CFG_MIN_H:  lim_lo = v[31:0];
      CFG_SEG_T:  seg_time = v[30:0];
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_limits(logic [47:0] r2, logic [31:0] hi, logic [31:0] lo,
                              logic [30:0] st);
    write_reg(CFG_MAX_R2, r2);
    write_reg(CFG_MAX_H, {16'd0, hi});
    write_reg(CFG_MIN_H, {16'd0, lo});
    write_reg(CFG_SEG_T, {17'd0, st});
  endtask

  // Waits until every word has gone in and every result has come out, then
  // gives silent commands time to finish.
  task automatic drain();
    while (pend_q.size() != 0 || in_valid || want_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: pend_q.push_back(cmd(CODE_RELATIVE, 0, 0, 0, 0, 0, 0));
        1: pend_q.push_back(cmd(CODE_ABSOLUTE, 0, 0, 0, 0, 0, 0));
        2, 3, 4: pend_q.push_back(rand_control());
        default: pend_q.push_back(rand_move());
      endcase
    end
    drain();
  endtask

  initial begin
    lim_r2 = 48'hFFFF_FFFF_FFFF;
    lim_hi = 32'sh7FFF_FFFF;
    lim_lo = 32'sh8000_0000;
    seg_time = 31'd65536;
    pos_x = 0; pos_y = 0; pos_z = 0; known = 0;
    ext_pos[0] = 0; ext_pos[1] = 0; ext_pos[2] = 0;
    feed_cur = DEFAULT_FEED; tool = 0; abs_mode = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    write_limits(48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'd65536);

    // Control codes and their corner values.
    pend_q.push_back(cmd(CODE_HOME, 0, 0, 0, 0, 0, 0));
    pend_q.push_back(cmd(8'h00, 0, 0, 0, 0, 0, 0));
    pend_q.push_back(cmd(8'h40, 16'hFFFF, 0, 0, 0, 0, 0));
    pend_q.push_back(cmd(8'h30, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
    pend_q.push_back(cmd(8'h20, 0, 0, 0, 0, 0, 32'h8000_0000));
    pend_q.push_back(cmd(8'h20, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
    pend_q.push_back(cmd(8'h1F, 0, 0, 0, 0, 0, 32'h00D2_0000));
    pend_q.push_back(cmd(8'h13, 0, 0, 0, 0, 0, 32'hFFFF_0000));
    pend_q.push_back(cmd(CODE_PAUSE_A, 0, 0, 0, 0, 0, 32'h0003_0000));
    pend_q.push_back(cmd(CODE_PAUSE_0, 0, 0, 0, 0, 0, 32'h1234));
    pend_q.push_back(cmd(CODE_PAUSE_H, 0, 0, 0, 0, 0, 0));
    pend_q.push_back(cmd(8'h0C, 0, 0, 0, 0, 0, 32'hFFFE_8000));
    // A move with no axis known yet gives only the target word.
    pend_q.push_back(cmd(8'hFC, 16'd100, 32'h0010_0000, 32'h0008_0000, 32'h0001_0000,
                         32'h0000_8000, 0));
    // Interpolated move, then a tool change to the second extruder.
    pend_q.push_back(cmd(8'hBC, 0, 32'hFFF0_0000, 32'h0, 32'h0002_0000, 32'h0001_0000, 0));
    pend_q.push_back(cmd(8'hE2, 16'd50, 32'h0014_0000, 32'h0, 0, 32'h0002_0000, 0));
    pend_q.push_back(cmd(8'h87, 0, 0, 0, 0, 0, 0));
    // Relative mode, then huge deltas that need halving.
    pend_q.push_back(cmd(CODE_RELATIVE, 0, 0, 0, 0, 0, 0));
    pend_q.push_back(cmd(8'h89, 16'd1, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    pend_q.push_back(cmd(CODE_ABSOLUTE, 0, 0, 0, 0, 0, 0));
    pend_q.push_back(cmd(8'hF8, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         0, 0));
    pend_q.push_back(cmd(8'hF8, 16'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
    drain();

    // Tight limits: range errors on radius and height.
    write_limits(48'd10000 << 16, 32'h0032_0000, 32'hFFFB_0000, 31'd1);
    pend_q.push_back(cmd(8'hB8, 0, 32'h0064_0000, 32'h0001_0000, 0, 0, 0));
    pend_q.push_back(cmd(8'hB8, 0, 32'h0005_0000, 32'h0005_0000, 32'h0033_0000, 0, 0));
    pend_q.push_back(cmd(8'hB8, 0, 32'h0005_0000, 32'h0005_0000, 32'hFFFA_0000, 0, 0));
    pend_q.push_back(cmd(8'hBC, 0, 32'h0005_0000, 32'h0005_0000, 32'h0001_0000, 0, 0));
    random_phase(40);

    write_limits(48'd0, 32'h0, 32'h0, 31'h7FFF_FFFF);
    random_phase(30);

    write_limits(48'({$urandom, $urandom}), $urandom, $urandom,
                 31'($urandom_range(1, 200000)));
    random_phase(30);

    write_limits(48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'd65536);
    random_phase(35);

    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
